[hw/rtl/direct_mapped_row_cache_tags_top_assert.svh]
// Assertion macros for the direct-mapped row cache tag controller.
// Used by direct_mapped_row_cache_tags_top; needs clk and rst_n in scope.
`ifndef DIRECT_MAPPED_ROW_CACHE_TAGS_TOP_ASSERT_SVH
`define DIRECT_MAPPED_ROW_CACHE_TAGS_TOP_ASSERT_SVH

// The condition must never hold outside reset.
`define DMRC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define DMRC_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dmrc_pkg.sv]
// Shared types and constants for the direct-mapped row cache tag controller.
// No dependencies; every other RTL module imports this package.
package dmrc_pkg;

  localparam int ROW_BITS   = 17;  // magnitude bits of a non-negative row id
  localparam int RID_W      = 18;  // signed row id width on the input
  localparam int OWN_W      = 18;  // owned range register width
  localparam int SLOT_OUT_W = 12;  // cache_slot field width
  localparam int TOTAL_W    = 32;  // hit and miss totals
  localparam int APB_W      = 32;
  localparam int PADDR_W    = 3;

  localparam logic [OWN_W-1:0] OWN_LOW_RST  = 18'd0;
  localparam logic [OWN_W-1:0] OWN_HIGH_RST = 18'd64640;

  // Register indexes, taken from paddr[2].
  localparam logic REG_OWN_LOW  = 1'b0;
  localparam logic REG_OWN_HIGH = 1'b1;

  // Operation codes on the input.
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SKIP   = 2'd0;
  localparam logic [1:0] KIND_HIT    = 2'd1;
  localparam logic [1:0] KIND_MISS   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // Command classes passed from the front to the back.
  localparam logic [1:0] CMD_SKIP   = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;
  localparam logic [1:0] CMD_COMMIT = 2'd3;

  // Bit positions in the sticky failure flags.
  localparam int FLG_CHANGED = 0;
  localparam int FLG_IO      = 1;

  typedef struct packed {
    logic [1:0]          cls;
    logic [ROW_BITS-1:0] id;
    logic                changed;
    logic                io;
    logic                poison;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

[hw/rtl/dmrc_front.sv]
// Front end: accepts input words, tracks batch state and sticky flags,
// and turns each word into a command. Depends on dmrc_pkg.
module dmrc_front
  import dmrc_pkg::*;
#(
  parameter int BATCH_MAX = 256,
  parameter int ID_BITS   = 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic signed [RID_W-1:0] in_row_id,
  input  logic                    in_file_changed,
  input  logic                    in_read_failed,
  input  logic [OWN_W-1:0]        owned_low,
  input  logic [OWN_W-1:0]        owned_high,
  input  logic                    q_full,
  input  back_stat_t              back_stat,
  output logic                    push,
  output cmd_t                    push_cmd
);

  localparam int SEEN_W = $clog2(BATCH_MAX + 1);
  localparam int ID_W   = (ID_BITS < ROW_BITS) ? ID_BITS : ROW_BITS;

  logic [1:0]          flags_r, flags_nxt;
  logic                open_r, open_nxt;
  logic [SEEN_W-1:0]   seen_r, seen_nxt;
  logic [ROW_BITS-1:0] id17;
  logic                owned;
  logic                seen_full;
  logic [1:0]          merged;
  cmd_t                cmd;

  assign in_ready  = !q_full && !back_stat.clearing;
  assign push      = in_valid && in_ready;
  assign push_cmd  = cmd;
  assign id17      = in_row_id[ROW_BITS-1:0];
  assign seen_full = (seen_r >= SEEN_W'(BATCH_MAX));
  assign merged    = flags_r | {in_read_failed, in_file_changed};

  // Negative ids, ids too wide for the id space and ids outside the owned
  // window are all treated alike.
  assign owned = !in_row_id[RID_W-1] && ((id17 >> ID_W) == '0) &&
                 ({1'b0, id17} >= owned_low) && ({1'b0, id17} < owned_high);

  always_comb begin
    flags_nxt = flags_r;
    open_nxt  = open_r;
    seen_nxt  = seen_r;
    cmd       = '0;
    cmd.cls   = CMD_SKIP;
    cmd.id    = id17;
    case (in_operation)
      OP_BEGIN: begin
        cmd.cls = CMD_STATUS;
        if (flags_r != 2'b00) begin
          open_nxt   = 1'b0;
          cmd.poison = 1'b1;
        end else if (in_file_changed) begin
          flags_nxt              = 2'b00;
          flags_nxt[FLG_CHANGED] = 1'b1;
          open_nxt               = 1'b0;
          cmd.changed            = 1'b1;
        end else begin
          open_nxt = 1'b1;
          seen_nxt = '0;
        end
      end
      OP_LOOKUP: begin
        if (open_r && !seen_full) begin
          seen_nxt = seen_r + SEEN_W'(1);
          if (owned) begin
            cmd.cls = CMD_LOOKUP;
          end
        end
      end
      OP_END: begin
        if (open_r) begin
          flags_nxt   = merged;
          open_nxt    = 1'b0;
          seen_nxt    = '0;
          cmd.cls     = (merged == 2'b00) ? CMD_COMMIT : CMD_STATUS;
          cmd.changed = merged[FLG_CHANGED];
          cmd.io      = merged[FLG_IO];
        end else begin
          cmd.cls     = CMD_STATUS;
          cmd.changed = flags_r[FLG_CHANGED];
          cmd.io      = flags_r[FLG_IO];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= 2'b00;
      open_r  <= 1'b0;
      seen_r  <= '0;
    end else if (push) begin
      flags_r <= flags_nxt;
      open_r  <= open_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

[hw/rtl/dmrc_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on dmrc_pkg for the command type.
module dmrc_fifo
  import dmrc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_v,
  output cmd_t head_cmd,
  input  logic pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             q_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign head_v   = (cnt_r != '0);
  assign head_cmd = q_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= bump(wptr_r);
      end
      if (pop) begin
        rptr_r <= bump(rptr_r);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/dmrc_back.sv]
// Back end: tag store lookups, miss list, commit walk, clearing pass and
// the result register with the saturating totals. Depends on dmrc_pkg.
module dmrc_back
  import dmrc_pkg::*;
#(
  parameter int SLOTS     = 4096,
  parameter int BATCH_MAX = 256,
  parameter int ID_BITS   = 17
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_v,
  input  cmd_t                  head_cmd,
  output logic                  pop,
  output back_stat_t            back_stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [SLOT_OUT_W-1:0] out_cache_slot,
  output logic                  out_changed_flag,
  output logic                  out_io_flag,
  output logic                  out_poisoned,
  output logic [TOTAL_W-1:0]    out_hit_total,
  output logic [TOTAL_W-1:0]    out_miss_total
);

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int ID_W      = (ID_BITS < ROW_BITS) ? ID_BITS : ROW_BITS;
  localparam int TAG_W     = (ID_W > SLOT_BITS) ? ID_W - SLOT_BITS : 1;
  localparam int PCNT_W    = $clog2(BATCH_MAX + 1);
  localparam int PIDX_W    = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  // Slot count is a power of two, so the slot is the low id bits and the
  // tag is what lies above them.
  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [ROW_BITS-1:0] id);
    logic [31:0] w;
    w = 32'(id);
    return w[SLOT_BITS-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [ROW_BITS-1:0] id);
    logic [31:0] w;
    w = 32'(id) >> SLOT_BITS;
    return w[TAG_W-1:0];
  endfunction

  logic [TAG_W:0]        tag_mem  [SLOTS];
  logic [ID_W-1:0]       pend_mem [BATCH_MAX];

  logic [1:0]            state_r, state_nxt;
  logic [SLOT_BITS-1:0]  clr_idx_r;
  logic [PCNT_W-1:0]     walk_idx_r;
  logic                  pw_v_r;
  logic [ID_W-1:0]       pdata_r;
  logic [TAG_W:0]        trd_r;
  logic                  b_v_r;
  cmd_t                  b_cmd_r;
  logic [PCNT_W-1:0]     pcnt_r;
  logic                  out_valid_r;
  logic [1:0]            out_kind_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic                  out_chg_r, out_io_r, out_poison_r;
  logic [TOTAL_W-1:0]    hit_r, miss_r;

  logic                  b_go, a_go, walk_start, walk_done, hit;
  logic                  tw_en, pr_en, pw_en;
  logic [SLOT_BITS-1:0]  tw_addr;
  logic [TAG_W:0]        tw_data;
  logic [ROW_BITS-1:0]   walk_id;
  logic [1:0]            kind_d;
  logic [SLOT_OUT_W-1:0] slot_d;
  logic                  chg_d, io_d, poison_d;
  logic [TOTAL_W-1:0]    hit_d, miss_d;
  cmd_t                  done_cmd;

  assign back_stat.clearing = (state_r == ST_CLEAR);

  // B stage moves on when the result register is free or being taken.
  assign b_go       = b_v_r && (!out_valid_r || out_ready);
  assign a_go       = (state_r == ST_RUN) && head_v && (head_cmd.cls != CMD_COMMIT) &&
                      (!b_v_r || b_go);
  // A commit waits for the B stage to empty so the last miss is in the list.
  assign walk_start = (state_r == ST_RUN) && head_v && (head_cmd.cls == CMD_COMMIT) &&
                      !b_v_r;
  assign pop        = a_go || walk_start;
  assign pr_en      = (state_r == ST_WALK) && (walk_idx_r < pcnt_r);
  assign walk_done  = (state_r == ST_WALK) && (walk_idx_r == pcnt_r) && !pw_v_r;
  assign walk_id    = ROW_BITS'(pdata_r);
  assign hit        = trd_r[TAG_W] && (trd_r[TAG_W-1:0] == tag_of(b_cmd_r.id));

  always_comb begin
    done_cmd     = '0;
    done_cmd.cls = CMD_STATUS;
  end

  // One write port shared by the clearing pass and the commit walk.
  always_comb begin
    tw_en   = 1'b0;
    tw_addr = slot_of(walk_id);
    tw_data = {1'b1, tag_of(walk_id)};
    if (state_r == ST_CLEAR) begin
      tw_en   = 1'b1;
      tw_addr = clr_idx_r;
      tw_data = '0;
    end else if (pw_v_r) begin
      tw_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      tag_mem[tw_addr] <= tw_data;
    end
    if (a_go) begin
      trd_r <= tag_mem[slot_of(head_cmd.id)];
    end
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      pend_mem[pcnt_r[PIDX_W-1:0]] <= b_cmd_r.id[ID_W-1:0];
    end
    if (pr_en) begin
      pdata_r <= pend_mem[walk_idx_r[PIDX_W-1:0]];
    end
  end

  // Result of the command in the B stage.
  always_comb begin
    kind_d   = KIND_SKIP;
    slot_d   = '0;
    chg_d    = 1'b0;
    io_d     = 1'b0;
    poison_d = 1'b0;
    hit_d    = hit_r;
    miss_d   = miss_r;
    pw_en    = 1'b0;
    case (b_cmd_r.cls)
      CMD_LOOKUP: begin
        slot_d = SLOT_OUT_W'(slot_of(b_cmd_r.id));
        if (hit) begin
          kind_d = KIND_HIT;
          hit_d  = hit_r + TOTAL_W'(hit_r != '1);
        end else begin
          kind_d = KIND_MISS;
          miss_d = miss_r + TOTAL_W'(miss_r != '1);
          pw_en  = b_go && (pcnt_r < PCNT_W'(BATCH_MAX));
        end
      end
      CMD_STATUS: begin
        kind_d   = KIND_STATUS;
        chg_d    = b_cmd_r.changed;
        io_d     = b_cmd_r.io;
        poison_d = b_cmd_r.poison;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_idx_r == SLOT_BITS'(SLOTS - 1)) state_nxt = ST_RUN;
      ST_RUN:   if (walk_start) state_nxt = ST_WALK;
      ST_WALK:  if (walk_done) state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_cmd_r <= head_cmd;
    end else if (walk_done) begin
      b_cmd_r <= done_cmd;
    end
    if (b_go) begin
      out_kind_r   <= kind_d;
      out_slot_r   <= slot_d;
      out_chg_r    <= chg_d;
      out_io_r     <= io_d;
      out_poison_r <= poison_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      walk_idx_r  <= '0;
      pw_v_r      <= 1'b0;
      b_v_r       <= 1'b0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= '0;
      miss_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + SLOT_BITS'(1);
      end
      if (walk_start) begin
        walk_idx_r <= '0;
      end else if (pr_en) begin
        walk_idx_r <= walk_idx_r + PCNT_W'(1);
      end
      pw_v_r <= pr_en;
      if (a_go || walk_done) begin
        b_v_r <= 1'b1;
      end else if (b_go) begin
        b_v_r <= 1'b0;
      end
      if (b_go && (b_cmd_r.cls == CMD_STATUS)) begin
        pcnt_r <= '0;
      end else if (pw_en) begin
        pcnt_r <= pcnt_r + PCNT_W'(1);
      end
      if (b_go) begin
        out_valid_r <= 1'b1;
        hit_r       <= hit_d;
        miss_r      <= miss_d;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_cache_slot   = out_slot_r;
  assign out_changed_flag = out_chg_r;
  assign out_io_flag      = out_io_r;
  assign out_poisoned     = out_poison_r;
  assign out_hit_total    = hit_r;
  assign out_miss_total   = miss_r;

endmodule

[hw/rtl/direct_mapped_row_cache_tags_top.sv]
// Path: an accepted word enters the command queue, then the tag read and B stage registers,
// then the result register. Begin, lookup and skipped words go one per cycle unless the queue
// or receiver backs up; a committing end word holds later ones for the one-entry-a-cycle walk.
// Reset: synchronous, active low; afterwards a clearing pass writes all SLOTS tag
// entries invalid, one per cycle, with in_ready held low.
`include "direct_mapped_row_cache_tags_top_assert.svh"

module direct_mapped_row_cache_tags_top
  import dmrc_pkg::*;
#(
  parameter int SLOTS     = 4096,  // power of two
  parameter int BATCH_MAX = 256,
  parameter int ID_BITS   = 17,
  parameter int QDEPTH    = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input words.
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic signed [RID_W-1:0] in_row_id,
  input  logic                    in_file_changed,
  input  logic                    in_read_failed,
  // Result words.
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic [SLOT_OUT_W-1:0]   out_cache_slot,
  output logic                    out_changed_flag,
  output logic                    out_io_flag,
  output logic                    out_poisoned,
  output logic [TOTAL_W-1:0]      out_hit_total,
  output logic [TOTAL_W-1:0]      out_miss_total,
  // Register port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [APB_W-1:0]        pwdata,
  output logic [APB_W-1:0]        prdata,
  output logic                    pready
);

  // The owned window registers sit at byte addresses 0 and 4. Only bit 2
  // of the address selects, so every write lands in one of them. Software
  // changes them only while no word is in flight.
  logic [OWN_W-1:0] own_low_r, own_high_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_OWN_HIGH) ? APB_W'(own_high_r) : APB_W'(own_low_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_low_r  <= OWN_LOW_RST;
      own_high_r <= OWN_HIGH_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_OWN_HIGH) begin
        own_high_r <= pwdata[OWN_W-1:0];
      end else begin
        own_low_r <= pwdata[OWN_W-1:0];
      end
    end
  end

  // The front end decides everything that does not need the tag store:
  // batch open/closed, the per-batch lookup limit, ownership, and the
  // sticky failure flags. Its commands queue up for the back end.
  logic       push, q_full, head_v, pop;
  cmd_t       push_cmd, head_cmd;
  back_stat_t back_stat;

  dmrc_front #(
    .BATCH_MAX(BATCH_MAX),
    .ID_BITS  (ID_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_row_id      (in_row_id),
    .in_file_changed(in_file_changed),
    .in_read_failed (in_read_failed),
    .owned_low      (own_low_r),
    .owned_high     (own_high_r),
    .q_full         (q_full),
    .back_stat      (back_stat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  dmrc_fifo #(
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .head_v  (head_v),
    .head_cmd(head_cmd),
    .pop     (pop)
  );

  // The back end reads the tag store for lookups (a registered read, then
  // the compare stage), records misses, and on a clean end walks the miss
  // list in order, so a repeated id's last write wins.
  dmrc_back #(
    .SLOTS    (SLOTS),
    .BATCH_MAX(BATCH_MAX),
    .ID_BITS  (ID_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_v          (head_v),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .back_stat       (back_stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_cache_slot  (out_cache_slot),
    .out_changed_flag(out_changed_flag),
    .out_io_flag     (out_io_flag),
    .out_poisoned    (out_poisoned),
    .out_hit_total   (out_hit_total),
    .out_miss_total  (out_miss_total)
  );

  // The queue is never written while full, and nothing enters while the
  // tag store is being cleared.
  `DMRC_NEVER(a_queue_overflow, push && q_full, "command queue written while full")
  `DMRC_NEVER(a_accept_in_clear, push && back_stat.clearing, "word accepted during clear")
  // Status fields are only ever set on a batch status word, and a status
  // word carries no slot.
  `DMRC_IMPLIES(a_flags_only_status, out_valid && (out_kind != KIND_STATUS), !out_changed_flag && !out_io_flag && !out_poisoned, "status flag on non-status word")
  `DMRC_IMPLIES(a_status_no_slot, out_valid && (out_kind == KIND_STATUS), out_cache_slot == '0, "slot set on status word")

endmodule

[tb/tb_direct_mapped_row_cache_tags_top.sv]
// Self-checking testbench for direct_mapped_row_cache_tags_top: batches of lookups run under
// random idling, with a scoreboard class that mirrors the tag store. Depends only on the RTL
// and on dmrc_pkg for port widths, operation codes, result kinds and register indexes.
module tb_direct_mapped_row_cache_tags_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmrc_pkg::*;

  // Geometry of the block as built with its default parameters.
  localparam int SLOT_COUNT = 4096;
  localparam int BATCH_LIMIT = 256;
  localparam int OWN_TOP = 131072;
  // The operation code that the block does not define. It must be answered as skipped.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  // The reset clearing pass runs with no handshake, so the watchdog sits well above its length,
  // above the long receiver hold and above a full commit walk.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SINK_HOLD = 400;
  // A commit walk runs before its status word is issued, so the final drain already waits for it.
  localparam int END_SETTLE = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [1:0]            kind;
    logic [SLOT_OUT_W-1:0] cache_slot;
    logic                  changed_flag;
    logic                  io_flag;
    logic                  poisoned;
    logic [TOTAL_W-1:0]    hit_total;
    logic [TOTAL_W-1:0]    miss_total;
  } row_result_t;

  // Mirror of the tag controller. It keeps its own copy of the tag store, the miss list of the
  // open batch, the sticky failure flags and the totals, and for each accepted input word it
  // queues the one result word that the block owes for it.
  class tag_mirror;
    logic [ROW_BITS-1:0] tag_id [SLOT_COUNT];
    bit                  tag_valid [SLOT_COUNT];
    logic [ROW_BITS-1:0] queued_misses [$];
    int unsigned         batch_lookups;
    logic [1:0]          sticky;
    bit                  batch_live;
    logic [TOTAL_W-1:0]  hits;
    logic [TOTAL_W-1:0]  misses;
    logic [OWN_W-1:0]    own_lo;
    logic [OWN_W-1:0]    own_hi;
    row_result_t         owed [$];
    int                  errors;

    function new();
      foreach (tag_valid[i]) tag_valid[i] = 1'b0;
      batch_lookups = 0;
      sticky = '0;
      batch_live = 1'b0;
      hits = '0;
      misses = '0;
      own_lo = OWN_LOW_RST;
      own_hi = OWN_HIGH_RST;
      errors = 0;
    endfunction

    function void note_word(logic [1:0] op, logic [RID_W-1:0] raw, logic chg, logic rdf);
      row_result_t r;
      logic [ROW_BITS-1:0] id;
      logic [SLOT_OUT_W-1:0] slot;
      r = '0;
      case (op)
        OP_BEGIN: begin
          r.kind = KIND_STATUS;
          if (sticky != 0) begin
            batch_live = 1'b0;
            r.poisoned = 1'b1;
          end else if (chg) begin
            sticky[FLG_CHANGED] = 1'b1;
            batch_live = 1'b0;
            r.changed_flag = 1'b1;
          end else begin
            // A begin while a batch is open simply drops the open one.
            batch_live = 1'b1;
            queued_misses.delete();
            batch_lookups = 0;
          end
        end
        OP_LOOKUP: begin
          r.kind = KIND_SKIP;
          if (batch_live && batch_lookups < BATCH_LIMIT) begin
            // Unowned ids still count against the batch limit.
            batch_lookups++;
            if (!raw[RID_W-1] && raw >= own_lo && raw < own_hi) begin
              id = raw[ROW_BITS-1:0];
              slot = SLOT_OUT_W'(id % SLOT_COUNT);
              r.cache_slot = slot;
              if (tag_valid[slot] && tag_id[slot] == id) begin
                r.kind = KIND_HIT;
                if (hits != '1) hits++;
              end else begin
                r.kind = KIND_MISS;
                queued_misses.push_back(id);
                if (misses != '1) misses++;
              end
            end
          end
        end
        OP_END: begin
          r.kind = KIND_STATUS;
          if (batch_live) begin
            if (chg) sticky[FLG_CHANGED] = 1'b1;
            if (rdf) sticky[FLG_IO] = 1'b1;
            // Tags are written in queue order, so a repeated miss leaves its last id.
            if (sticky == 0) begin
              foreach (queued_misses[i]) begin
                tag_id[queued_misses[i] % SLOT_COUNT] = queued_misses[i];
                tag_valid[queued_misses[i] % SLOT_COUNT] = 1'b1;
              end
            end
            batch_live = 1'b0;
            queued_misses.delete();
            batch_lookups = 0;
          end
          r.changed_flag = sticky[FLG_CHANGED];
          r.io_flag = sticky[FLG_IO];
        end
        default: r.kind = KIND_SKIP;
      endcase
      r.hit_total = hits;
      r.miss_total = misses;
      owed.push_back(r);
    endfunction

    function void match(string field, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(row_result_t got);
      row_result_t want;
      if (owed.size() == 0) begin
        if (errors < MAX_REPORTS) $error("result word arrived with nothing expected");
        errors++;
        return;
      end
      want = owed.pop_front();
      match("kind", TOTAL_W'(want.kind), TOTAL_W'(got.kind));
      match("cache_slot", TOTAL_W'(want.cache_slot), TOTAL_W'(got.cache_slot));
      match("changed_flag", TOTAL_W'(want.changed_flag), TOTAL_W'(got.changed_flag));
      match("io_flag", TOTAL_W'(want.io_flag), TOTAL_W'(got.io_flag));
      match("poisoned", TOTAL_W'(want.poisoned), TOTAL_W'(got.poisoned));
      match("hit_total", want.hit_total, got.hit_total);
      match("miss_total", want.miss_total, got.miss_total);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_operation;
  logic signed [RID_W-1:0] in_row_id;
  logic                    in_file_changed;
  logic                    in_read_failed;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              out_kind;
  logic [SLOT_OUT_W-1:0]   out_cache_slot;
  logic                    out_changed_flag;
  logic                    out_io_flag;
  logic                    out_poisoned;
  logic [TOTAL_W-1:0]      out_hit_total;
  logic [TOTAL_W-1:0]      out_miss_total;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [APB_W-1:0]        pwdata;
  logic [APB_W-1:0]        prdata;
  logic                    pready;

  tag_mirror mirror;

  // Random idling on both sides; switched off for the last part of the run.
  bit idling;
  // Raised by the stimulus to make the receiver hold off for a long stretch.
  bit sink_hold_req;
  // Forces one long batch, near or past the lookup limit, early in the random part.
  bit want_long_batch;
  // True while a batch was opened by the stimulus and never closed.
  bit batch_left_open;
  int unsigned words_sent;
  int unsigned stall_cycles;
  int cur_lo;
  int cur_hi;

  direct_mapped_row_cache_tags_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_row_id        (in_row_id),
    .in_file_changed  (in_file_changed),
    .in_read_failed   (in_read_failed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_cache_slot   (out_cache_slot),
    .out_changed_flag (out_changed_flag),
    .out_io_flag      (out_io_flag),
    .out_poisoned     (out_poisoned),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Every result word taken at an edge is checked against the oldest expectation. The outputs
  // are read as they stood just before the edge, so event order inside the step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      mirror.check_result('{out_kind, out_cache_slot, out_changed_flag, out_io_flag,
                            out_poisoned, out_hit_total, out_miss_total});
    end
  end

  // The watchdog counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL direct_mapped_row_cache_tags_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver side. Each pass through the loop sets out_ready once and may then hold it for a
  // burst. The long hold lets the sender keep offering words until the block backs up.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one word and returns at the edge that accepts it. Valid stays high from one word to
  // the next unless an idle burst is drawn, so no step sees valid both lowered and raised.
  task automatic send_word(logic [1:0] op, logic [RID_W-1:0] row, logic chg, logic rdf);
    if (idling && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_row_id <= row;
    in_file_changed <= chg;
    in_read_failed <= rdf;
    do @(posedge clk); while (!in_ready);
    mirror.note_word(op, row, chg, rdf);
    words_sent++;
  endtask

  // Stops offering and waits until every expected result word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic reg_sel, logic [OWN_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= APB_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_OWN_LOW) mirror.own_lo = value;
    else mirror.own_hi = value;
  endtask

  // Row ids mostly come from a small pool at the bottom of the owned range so that committed
  // misses turn into hits. Some alias the same slots with another tag, some sit on the range
  // edges, and the rest are negative or anywhere in the field.
  function automatic logic [RID_W-1:0] pick_row();
    int span;
    int v;
    int sel;
    span = (cur_hi > cur_lo) ? cur_hi - cur_lo : 1;
    if (span > 160) span = 160;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      v = cur_lo + $urandom_range(0, span - 1);
    end else if (sel < 72) begin
      v = cur_lo + $urandom_range(0, span - 1) + SLOT_COUNT * $urandom_range(1, 3);
    end else if (sel < 82) begin
      case ($urandom_range(0, 3))
        0: v = cur_lo - 1;
        1: v = cur_lo;
        2: v = cur_hi - 1;
        default: v = cur_hi;
      endcase
    end else if (sel < 91) begin
      v = -int'($urandom_range(1, OWN_TOP));
    end else begin
      v = $urandom_range(0, 2 * OWN_TOP - 1);
    end
    return v[RID_W-1:0];
  endfunction

  // A well-formed batch: begin, lookups, end, with both failure inputs low where they count.
  // Leaving it unclosed makes the next begin drop it.
  task automatic run_batch(int lookups, bit close);
    send_word(OP_BEGIN, pick_row(), 1'b0, 1'($urandom_range(0, 1)));
    repeat (lookups) begin
      send_word(OP_LOOKUP, pick_row(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    if (close) send_word(OP_END, pick_row(), 1'b0, 1'b0);
    batch_left_open = !close;
  endtask

  // Stray words between batches. An end with no batch open ignores its failure inputs, so
  // those are random only then; otherwise it would make the failure flags sticky too early.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_word(OP_LOOKUP, pick_row(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      1: begin
        if (batch_left_open) send_word(OP_END, pick_row(), 1'b0, 1'b0);
        else send_word(OP_END, pick_row(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        batch_left_open = 1'b0;
      end
      2: send_word(OP_UNDEFINED, pick_row(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      default: begin
        send_word(OP_BEGIN, pick_row(), 1'b0, 1'($urandom_range(0, 1)));
        batch_left_open = 1'b1;
      end
    endcase
  endtask

  // One setting of the owned range, written while the block is idle, then random batches
  // until the word budget is spent.
  task automatic run_phase(int lo, int hi, int budget, bit idle_on, bit squeeze);
    int unsigned stop_at;
    int n;
    drain();
    cur_lo = lo;
    cur_hi = hi;
    write_reg(REG_OWN_LOW, OWN_W'(lo));
    write_reg(REG_OWN_HIGH, OWN_W'(hi));
    idling = idle_on;
    if (squeeze) sink_hold_req = 1'b1;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      if (want_long_batch || $urandom_range(0, 29) == 0) n = $urandom_range(250, 264);
      else n = $urandom_range(0, 24);
      want_long_batch = 1'b0;
      run_batch(n, $urandom_range(0, 9) != 0);
    end
  endtask

  // Runs at the reset owned range. Covers lookups and ends with no batch open, the undefined
  // operation, the field extremes, a repeated miss in one slot, begin while open, and hits.
  task automatic run_directed();
    send_word(OP_LOOKUP, 18'd5, 1'b0, 1'b0);
    send_word(OP_END, 18'd0, 1'b1, 1'b1);
    send_word(OP_UNDEFINED, 18'h3FFFF, 1'b1, 1'b1);
    send_word(OP_BEGIN, 18'd0, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'd0, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'd64639, 1'b1, 1'b1);
    send_word(OP_LOOKUP, 18'd64640, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'h3FFFF, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'h20000, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'h1FFFF, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'd4096, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'd0, 1'b0, 1'b0);
    send_word(OP_END, 18'h3FFFF, 1'b0, 1'b0);
    send_word(OP_BEGIN, 18'd0, 1'b0, 1'b1);
    send_word(OP_BEGIN, 18'h3FFFF, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'd0, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'd4096, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'd64639, 1'b0, 1'b0);
    send_word(OP_UNDEFINED, 18'd0, 1'b0, 1'b0);
    send_word(OP_END, 18'd0, 1'b0, 1'b0);
    send_word(OP_LOOKUP, 18'd64639, 1'b0, 1'b0);
  endtask

  // The failure flags never clear, so they are raised only at the very end. Which way they get
  // set is drawn at random; after that every begin must come back poisoned.
  task automatic run_failure_tail();
    case ($urandom_range(0, 2))
      0: send_word(OP_BEGIN, pick_row(), 1'b1, 1'($urandom_range(0, 1)));
      1: begin
        run_batch($urandom_range(1, 8), 1'b0);
        send_word(OP_END, pick_row(), 1'($urandom_range(0, 1)), 1'b1);
      end
      default: begin
        run_batch($urandom_range(1, 8), 1'b0);
        send_word(OP_END, pick_row(), 1'b1, 1'b0);
      end
    endcase
    send_word(OP_END, pick_row(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    send_word(OP_BEGIN, pick_row(), 1'b0, 1'b0);
    repeat (3) send_word(OP_LOOKUP, pick_row(), 1'b0, 1'b0);
    send_word(OP_BEGIN, pick_row(), 1'b1, 1'b1);
    send_word(OP_END, pick_row(), 1'b0, 1'b0);
  endtask

  initial begin
    int lo;
    mirror = new();
    idling = 1'b1;
    sink_hold_req = 1'b0;
    want_long_batch = 1'b1;
    batch_left_open = 1'b0;
    words_sent = 0;
    stall_cycles = 0;
    cur_lo = 0;
    cur_hi = int'(OWN_HIGH_RST);
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_BEGIN;
    in_row_id <= '0;
    in_file_changed <= 1'b0;
    in_read_failed <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The block holds in_ready low through its clearing pass; the first word simply waits.
    run_directed();

    // Owned ranges go through the full field, the top half, a random window, the empty ranges
    // at both ends, a reversed range, a narrow band at the top and a band low down. The second
    // phase also carries the long receiver hold.
    run_phase(0, OWN_TOP, 300, 1'b1, 1'b0);
    run_phase(65536, OWN_TOP, 250, 1'b1, 1'b1);
    lo = $urandom_range(0, 120000);
    run_phase(lo, (lo + 12000 > OWN_TOP) ? OWN_TOP : lo + $urandom_range(1, 12000),
              250, 1'b1, 1'b0);
    run_phase(OWN_TOP, OWN_TOP, 60, 1'b1, 1'b0);
    run_phase(0, 0, 60, 1'b0, 1'b0);
    run_phase(90000, 20000, 40, 1'b1, 1'b0);
    run_phase(130000, OWN_TOP, 200, 1'b1, 1'b0);
    run_phase(4000, 12000, 200, 1'b1, 1'b0);

    // Last part: the reset range again, with no idling on either side.
    run_phase(0, int'(OWN_HIGH_RST), 250, 1'b0, 1'b0);
    run_failure_tail();

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (mirror.errors == 0 && mirror.owed.size() == 0) begin
      $display("PASS direct_mapped_row_cache_tags_top");
    end else begin
      $display("FAIL direct_mapped_row_cache_tags_top");
    end
    $finish;
  end

endmodule
